FILE: design/mqf_pkg.sv
// Package for the multi-queue FIFO manager: sizes, command and status codes,
// queue table entry and active-bit control types. No dependencies.
`timescale 1ns / 1ps

package mqf_pkg;

  localparam int NUM_QUEUES    = 16;
  localparam int MAX_DEPTH     = 256;
  localparam int DEFAULT_DEPTH = 256;
  localparam int DATA_WIDTH    = 32;

  localparam int CMD_W   = 3;
  localparam int QSEL_W  = 4;
  localparam int STAT_W  = 3;
  localparam int QW      = (NUM_QUEUES > 1) ? $clog2(NUM_QUEUES) : 1;
  localparam int AW      = (MAX_DEPTH > 1) ? $clog2(MAX_DEPTH) : 1;
  localparam int CNT_W   = $clog2(MAX_DEPTH + 1);
  localparam int SUM_W   = CNT_W + 1;
  localparam int STORE_DEPTH = NUM_QUEUES * (2 ** AW);
  localparam int STORE_AW    = QW + AW;
  localparam int DEF_DEPTH_SAT = (DEFAULT_DEPTH > MAX_DEPTH) ? MAX_DEPTH : DEFAULT_DEPTH;

  typedef enum logic [CMD_W-1:0] {
    CMD_ALLOC = 3'd0,
    CMD_PUT   = 3'd1,
    CMD_GET   = 3'd2,
    CMD_COUNT = 3'd3,
    CMD_FREE  = 3'd4
  } cmd_t;

  typedef enum logic [STAT_W-1:0] {
    ST_OK       = 3'd0,
    ST_NOQUEUE  = 3'd1,
    ST_INACTIVE = 3'd2,
    ST_FULL     = 3'd3,
    ST_EMPTY    = 3'd4
  } status_t;

  typedef struct packed {
    logic [AW-1:0]    head;
    logic [CNT_W-1:0] count;
    logic [CNT_W-1:0] depth;
  } qent_t;

  typedef struct packed {
    logic          set;
    logic [QW-1:0] set_idx;
    logic          clr;
    logic [QW-1:0] clr_idx;
  } act_ctl_t;

endpackage

FILE: design/multi_queue_fifo_manager_core.sv
// Flow: a command accepted in S_IDLE reads the queue table (S_LOOKUP); a get that returns a
// word also reads the entry store (S_FETCH); the result register then holds it (S_RESULT)
// until the output is free. No new command is taken until the result has been registered out.
// Reset (rst, synchronous): all queues inactive, no result pending; the entry store is
// not cleared. Depends on mqf_pkg, mqf_ram, mqf_qsel.
`timescale 1ns / 1ps

module multi_queue_fifo_manager_core import mqf_pkg::*; (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  in_valid,
  output logic                  in_ready,
  input  logic [CMD_W-1:0]      cmd,
  input  logic [QSEL_W-1:0]     queue_sel,
  input  logic [CNT_W-1:0]      req_depth,
  input  logic [DATA_WIDTH-1:0] data_in,
  output logic                  out_valid,
  input  logic                  out_ready,
  output logic [STAT_W-1:0]     status,
  output logic [QSEL_W-1:0]     queue_id,
  output logic [DATA_WIDTH-1:0] data_out,
  output logic [CNT_W-1:0]      fill_count
);

  typedef enum logic [1:0] {S_IDLE, S_LOOKUP, S_FETCH, S_RESULT} state_t;

  state_t                state;
  logic [CMD_W-1:0]      c_cmd;
  logic [QSEL_W-1:0]     c_q;
  logic [CNT_W-1:0]      c_req;
  logic [DATA_WIDTH-1:0] c_data;
  logic [STAT_W-1:0]     res_status;
  logic [QSEL_W-1:0]     res_qid;
  logic [DATA_WIDTH-1:0] res_dout;
  logic [CNT_W-1:0]      res_fill;

  logic                  accept;
  logic                  qtab_we;
  logic [QW-1:0]         qtab_waddr;
  qent_t                 qtab_wdata;
  qent_t                 qe;
  logic                  st_we;
  logic                  st_re;
  logic [STORE_AW-1:0]   st_waddr;
  logic [STORE_AW-1:0]   st_raddr;
  logic [DATA_WIDTH-1:0] st_rdata;
  act_ctl_t              act_ctl;
  logic [NUM_QUEUES-1:0] active;
  logic                  free_found;
  logic [QW-1:0]         free_idx;
  logic                  q_ok;
  logic [CNT_W-1:0]      alloc_depth;
  logic [SUM_W-1:0]      put_sum;
  logic [AW-1:0]         put_pos;
  logic [SUM_W-1:0]      head_sum;
  logic [AW-1:0]         head_next;
  logic [STAT_W-1:0]     r_status;
  logic [QSEL_W-1:0]     r_qid;
  logic [CNT_W-1:0]      r_fill;
  logic                  go_fetch;
  logic                  out_free;

  assign accept   = in_valid && in_ready;
  assign in_ready = (state == S_IDLE);
  assign out_free = !out_valid || out_ready;

  mqf_ram #(.WIDTH($bits(qent_t)), .DEPTH(NUM_QUEUES)) u_qtab (
    .clk   (clk),
    .we    (qtab_we),
    .waddr (qtab_waddr),
    .wdata (qtab_wdata),
    .re    (accept),
    .raddr (queue_sel[QW-1:0]),
    .rdata (qe)
  );

  mqf_ram #(.WIDTH(DATA_WIDTH), .DEPTH(STORE_DEPTH)) u_store (
    .clk   (clk),
    .we    (st_we),
    .waddr (st_waddr),
    .wdata (c_data),
    .re    (st_re),
    .raddr (st_raddr),
    .rdata (st_rdata)
  );

  mqf_qsel u_qsel (
    .clk        (clk),
    .rst        (rst),
    .ctl        (act_ctl),
    .active     (active),
    .free_found (free_found),
    .free_idx   (free_idx)
  );

  always_comb begin
    q_ok = (32'(c_q) < NUM_QUEUES) && active[c_q[QW-1:0]];

    if (c_req == '0) begin
      alloc_depth = CNT_W'(DEF_DEPTH_SAT);
    end else if (32'(c_req) > MAX_DEPTH) begin
      alloc_depth = CNT_W'(MAX_DEPTH);
    end else begin
      alloc_depth = c_req;
    end

    put_sum = SUM_W'(qe.head) + SUM_W'(qe.count);
    if (put_sum >= SUM_W'(qe.depth)) begin
      put_sum = put_sum - SUM_W'(qe.depth);
    end
    put_pos = put_sum[AW-1:0];

    head_sum = SUM_W'(qe.head) + SUM_W'(1);
    if (head_sum >= SUM_W'(qe.depth)) begin
      head_sum = head_sum - SUM_W'(qe.depth);
    end
    head_next = head_sum[AW-1:0];
  end

  always_comb begin
    qtab_we    = 1'b0;
    qtab_waddr = c_q[QW-1:0];
    qtab_wdata = qe;
    st_we      = 1'b0;
    st_waddr   = {c_q[QW-1:0], put_pos};
    st_re      = 1'b0;
    st_raddr   = {c_q[QW-1:0], qe.head};
    act_ctl    = '0;
    r_status   = ST_OK;
    r_qid      = '0;
    r_fill     = '0;
    go_fetch   = 1'b0;
    if (state == S_LOOKUP) begin
      case (c_cmd)
        CMD_ALLOC: begin
          if (free_found) begin
            qtab_we          = 1'b1;
            qtab_waddr       = free_idx;
            qtab_wdata.head  = '0;
            qtab_wdata.count = '0;
            qtab_wdata.depth = alloc_depth;
            act_ctl.set      = 1'b1;
            act_ctl.set_idx  = free_idx;
            r_qid            = QSEL_W'(free_idx);
          end else begin
            r_status = ST_NOQUEUE;
          end
        end
        CMD_PUT: begin
          if (!q_ok) begin
            r_status = ST_INACTIVE;
          end else if (qe.count >= qe.depth) begin
            r_status = ST_FULL;
            r_fill   = qe.count;
          end else begin
            st_we            = 1'b1;
            qtab_we          = 1'b1;
            qtab_wdata.count = qe.count + CNT_W'(1);
            r_fill           = qe.count + CNT_W'(1);
          end
        end
        CMD_GET: begin
          if (!q_ok) begin
            r_status = ST_INACTIVE;
          end else if (qe.count == '0) begin
            r_status = ST_EMPTY;
          end else begin
            st_re            = 1'b1;
            go_fetch         = 1'b1;
            qtab_we          = 1'b1;
            qtab_wdata.head  = head_next;
            qtab_wdata.count = qe.count - CNT_W'(1);
            r_fill           = qe.count - CNT_W'(1);
          end
        end
        CMD_COUNT: begin
          if (!q_ok) begin
            r_status = ST_INACTIVE;
          end else begin
            r_fill = qe.count;
          end
        end
        CMD_FREE: begin
          if (!q_ok) begin
            r_status = ST_INACTIVE;
          end else begin
            qtab_we          = 1'b1;
            qtab_wdata.head  = '0;
            qtab_wdata.count = '0;
            act_ctl.clr      = 1'b1;
            act_ctl.clr_idx  = c_q[QW-1:0];
          end
        end
        default: begin
          r_status = ST_OK;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      out_valid <= 1'b0;
    end else begin
      if (out_valid && out_ready && state != S_RESULT) begin
        out_valid <= 1'b0;
      end
      case (state)
        S_IDLE: begin
          if (accept) begin
            c_cmd  <= cmd;
            c_q    <= queue_sel;
            c_req  <= req_depth;
            c_data <= data_in;
            state  <= S_LOOKUP;
          end
        end
        S_LOOKUP: begin
          res_status <= r_status;
          res_qid    <= r_qid;
          res_fill   <= r_fill;
          res_dout   <= '0;
          state      <= go_fetch ? S_FETCH : S_RESULT;
        end
        S_FETCH: begin
          res_dout <= st_rdata;
          state    <= S_RESULT;
        end
        S_RESULT: begin
          if (out_free) begin
            out_valid  <= 1'b1;
            status     <= res_status;
            queue_id   <= res_qid;
            data_out   <= res_dout;
            fill_count <= res_fill;
            state      <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

endmodule

FILE: design/mqf_ram.sv
// Generic single-write, single-read synchronous RAM with registered read data.
// No dependencies.
`timescale 1ns / 1ps

module mqf_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

FILE: design/mqf_qsel.sv
// Queue active bits and lowest-inactive-queue search.
// Depends on mqf_pkg.
`timescale 1ns / 1ps

module mqf_qsel import mqf_pkg::*; (
  input  logic                  clk,
  input  logic                  rst,
  input  act_ctl_t              ctl,
  output logic [NUM_QUEUES-1:0] active,
  output logic                  free_found,
  output logic [QW-1:0]         free_idx
);

  always_ff @(posedge clk) begin
    if (rst) begin
      active <= '0;
    end else begin
      if (ctl.set) begin
        active[ctl.set_idx] <= 1'b1;
      end
      if (ctl.clr) begin
        active[ctl.clr_idx] <= 1'b0;
      end
    end
  end

  always_comb begin
    free_found = 1'b0;
    free_idx   = '0;
    for (int i = NUM_QUEUES - 1; i >= 0; i--) begin
      if (!active[i]) begin
        free_found = 1'b1;
        free_idx   = QW'(i);
      end
    end
  end

endmodule

FILE: design/mqf_checker.sv
// Port-level checker for the multi-queue FIFO manager, bound to the top level.
// Depends on mqf_pkg and multi_queue_fifo_manager_core.
`timescale 1ns / 1ps

module mqf_checker import mqf_pkg::*; (
  input logic                  clk,
  input logic                  rst,
  input logic                  in_valid,
  input logic                  in_ready,
  input logic                  out_valid,
  input logic                  out_ready,
  input logic [STAT_W-1:0]     status,
  input logic [QSEL_W-1:0]     queue_id,
  input logic [DATA_WIDTH-1:0] data_out,
  input logic [CNT_W-1:0]      fill_count
);

  a_reset_clears_out: assert property (@(posedge clk) rst |=> !out_valid)
    else $error("result valid after reset");

  a_one_at_a_time: assert property (@(posedge clk) disable iff (rst)
    in_valid && in_ready |=> !in_ready)
    else $error("command accepted while another is in flight");

  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(status) && $stable(data_out)
      && $stable(fill_count) && $stable(queue_id))
    else $error("stalled result changed");

  a_refusal_clean: assert property (@(posedge clk) disable iff (rst)
    out_valid && status != ST_OK |-> data_out == '0 && queue_id == '0)
    else $error("refused command carries data or queue id");

  a_noqueue_fill: assert property (@(posedge clk) disable iff (rst)
    out_valid && (status == ST_NOQUEUE || status == ST_INACTIVE) |-> fill_count == '0)
    else $error("fill count on refused alloc or inactive queue");

endmodule

bind multi_queue_fifo_manager_core mqf_checker u_mqf_checker (.*);

FILE: verif/tb_multi_queue_fifo_manager_core.sv
// Testbench for multi_queue_fifo_manager_core: directed table, then random command streams
// checked word by word against an in-bench queue-pool predictor. Depends on mqf_pkg.
`timescale 1ns / 1ps

module tb_multi_queue_fifo_manager_core;
  import mqf_pkg::*;

  localparam logic [CMD_W-1:0] CMD_SPARE_LO = 3'd5;
  localparam logic [CMD_W-1:0] CMD_SPARE_HI = 3'd7;
  localparam int REQ_MAX = (1 << CNT_W) - 1;
  localparam int CYCLE_LIMIT = 500000;
  localparam int PHASE_WORDS = 534;
  localparam int BURST_LEN = 48;
  localparam int RX_HOLD_CYCLES = 300;

  typedef struct {
    status_t                status;
    logic [QSEL_W-1:0]      qid;
    logic [DATA_WIDTH-1:0]  data;
    logic [CNT_W-1:0]       fill;
  } mq_result_t;

  typedef struct {
    logic [CMD_W-1:0]       c;
    logic [QSEL_W-1:0]      qs;
    logic [CNT_W-1:0]       rd;
    logic [DATA_WIDTH-1:0]  din;
    bit                     typed;
    mq_result_t             want;
  } dir_row_t;

  logic                  clk;
  logic                  rst;
  logic                  in_valid;
  logic                  in_ready;
  logic [CMD_W-1:0]      cmd;
  logic [QSEL_W-1:0]     queue_sel;
  logic [CNT_W-1:0]      req_depth;
  logic [DATA_WIDTH-1:0] data_in;
  logic                  out_valid;
  logic                  out_ready;
  logic [STAT_W-1:0]     status;
  logic [QSEL_W-1:0]     queue_id;
  logic [DATA_WIDTH-1:0] data_out;
  logic [CNT_W-1:0]      fill_count;

  bit                    q_live [NUM_QUEUES];
  int                    q_head [NUM_QUEUES];
  int                    q_fill [NUM_QUEUES];
  int                    q_depth [NUM_QUEUES];
  logic [DATA_WIDTH-1:0] q_words [NUM_QUEUES][MAX_DEPTH];

  mq_result_t pending_results[$];
  dir_row_t   dir_rows[$];

  int src_idle_pct = 27;
  int snk_idle_pct = 70;
  int hold_req = 0;
  int errors = 0;
  int cycle_count = 0;
  int focus_q = 0;

  multi_queue_fifo_manager_core DUT (.*);

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  function automatic mq_result_t apply_command(input logic [CMD_W-1:0] c,
                                               input logic [QSEL_W-1:0] qs,
                                               input logic [CNT_W-1:0] rd,
                                               input logic [DATA_WIDTH-1:0] din);
    mq_result_t r;
    int depth;
    int slot;
    int q;
    r.status = ST_OK;
    r.qid = '0;
    r.data = '0;
    r.fill = '0;
    q = int'(qs);
    slot = -1;
    if (c == CMD_ALLOC) begin
      depth = (rd == 0) ? DEFAULT_DEPTH : int'(rd);
      if (depth > MAX_DEPTH) depth = MAX_DEPTH;
      for (int i = 0; i < NUM_QUEUES; i++)
        if (!q_live[i] && slot < 0) slot = i;
      if (slot < 0) begin
        r.status = ST_NOQUEUE;
      end else begin
        q_live[slot] = 1'b1;
        q_depth[slot] = depth;
        q_head[slot] = 0;
        q_fill[slot] = 0;
        r.qid = QSEL_W'(slot);
      end
    end else if (c <= CMD_FREE) begin
      if (q >= NUM_QUEUES || !q_live[q]) begin
        r.status = ST_INACTIVE;
      end else begin
        case (c)
          CMD_PUT: begin
            if (q_fill[q] >= q_depth[q]) begin
              r.status = ST_FULL;
            end else begin
              slot = q_head[q] + q_fill[q];
              if (slot >= q_depth[q]) slot -= q_depth[q];
              q_words[q][slot] = din;
              q_fill[q]++;
            end
          end
          CMD_GET: begin
            if (q_fill[q] == 0) begin
              r.status = ST_EMPTY;
            end else begin
              r.data = q_words[q][q_head[q]];
              q_head[q]++;
              if (q_head[q] >= q_depth[q]) q_head[q] -= q_depth[q];
              q_fill[q]--;
            end
          end
          CMD_FREE: begin
            q_live[q] = 1'b0;
            q_head[q] = 0;
            q_fill[q] = 0;
          end
          default: ;
        endcase
        r.fill = CNT_W'(q_fill[q]);
      end
    end
    return r;
  endfunction

  function automatic logic [QSEL_W-1:0] pick_target();
    int start;
    if (q_live[focus_q] && $urandom_range(99) < 60) return QSEL_W'(focus_q);
    if ($urandom_range(99) < 85) begin
      start = $urandom_range(NUM_QUEUES - 1);
      for (int i = 0; i < NUM_QUEUES; i++)
        if (q_live[(start + i) % NUM_QUEUES]) return QSEL_W'((start + i) % NUM_QUEUES);
    end
    return QSEL_W'($urandom_range(NUM_QUEUES - 1));
  endfunction

  task automatic add_row(input logic [CMD_W-1:0] c, input int qs, input int rd,
                         input logic [DATA_WIDTH-1:0] din, input bit typed,
                         input status_t st, input int qid, input logic [DATA_WIDTH-1:0] dout,
                         input int fill);
    dir_row_t row;
    row.c = c;
    row.qs = QSEL_W'(qs);
    row.rd = CNT_W'(rd);
    row.din = din;
    row.typed = typed;
    row.want.status = st;
    row.want.qid = QSEL_W'(qid);
    row.want.data = dout;
    row.want.fill = CNT_W'(fill);
    dir_rows.push_back(row);
  endtask

  task automatic send_word(input logic [CMD_W-1:0] c, input logic [QSEL_W-1:0] qs,
                           input logic [CNT_W-1:0] rd, input logic [DATA_WIDTH-1:0] din,
                           input bit typed, input mq_result_t want);
    mq_result_t pred;
    if ($urandom_range(99) < src_idle_pct) begin
      in_valid <= 1'b0;
      do @(posedge clk); while ($urandom_range(99) < src_idle_pct);
    end
    in_valid <= 1'b1;
    cmd <= c;
    queue_sel <= qs;
    req_depth <= rd;
    data_in <= din;
    do @(posedge clk); while (!in_ready);
    pred = apply_command(c, qs, rd, din);
    pending_results.push_back(typed ? want : pred);
  endtask

  task automatic run_phase(input int n_words, input int src_pct, input int snk_pct);
    logic [CMD_W-1:0]      c;
    logic [QSEL_W-1:0]     qs;
    logic [CNT_W-1:0]      rd;
    logic [DATA_WIDTH-1:0] din;
    int roll;
    int put_w;
    mq_result_t none;
    none.status = ST_OK;
    none.qid = '0;
    none.data = '0;
    none.fill = '0;
    put_w = 35;
    src_idle_pct = src_pct;
    snk_idle_pct = snk_pct;
    for (int k = 0; k < n_words; k++) begin
      if (k % BURST_LEN == 0) begin
        focus_q = pick_target();
        put_w = $urandom_range(1) ? 50 : 20;
      end
      qs = pick_target();
      rd = CNT_W'($urandom_range(REQ_MAX));
      din = $urandom;
      roll = $urandom_range(99);
      if (roll < 12) begin
        c = CMD_ALLOC;
        roll = $urandom_range(99);
        if (roll < 50) rd = CNT_W'($urandom_range(8, 1));
        else if (roll < 60) rd = '0;
        else if (roll < 70) rd = CNT_W'(MAX_DEPTH);
        else if (roll < 80) rd = CNT_W'($urandom_range(REQ_MAX, MAX_DEPTH + 1));
        else rd = CNT_W'($urandom_range(MAX_DEPTH - 1, 9));
      end else if (roll < 12 + put_w) begin
        c = CMD_PUT;
      end else if (roll < 82) begin
        c = CMD_GET;
      end else if (roll < 88) begin
        c = CMD_COUNT;
      end else if (roll < 95) begin
        c = CMD_FREE;
      end else begin
        c = CMD_W'($urandom_range(CMD_SPARE_HI, CMD_SPARE_LO));
      end
      send_word(c, qs, rd, din, 1'b0, none);
    end
  endtask

  task automatic check_field(input string what, input logic [DATA_WIDTH-1:0] want,
                             input logic [DATA_WIDTH-1:0] got);
    if (want !== got) begin
      $display("%0t: %s mismatch, expected %0h, actual %0h", $time, what, want, got);
      errors++;
    end
  endtask

  initial begin
    int hold_left;
    mq_result_t want;
    hold_left = 0;
    out_ready <= 1'b0;
    forever begin
      @(posedge clk);
      if (out_valid && out_ready) begin
        if (pending_results.size() == 0) begin
          $display("%0t: unexpected word, expected none, actual status %0h data %0h",
                   $time, status, data_out);
          errors++;
        end else begin
          want = pending_results.pop_front();
          check_field("status", DATA_WIDTH'(want.status), DATA_WIDTH'(status));
          check_field("queue_id", DATA_WIDTH'(want.qid), DATA_WIDTH'(queue_id));
          check_field("data_out", want.data, data_out);
          check_field("fill_count", DATA_WIDTH'(want.fill), DATA_WIDTH'(fill_count));
        end
      end
      if (hold_req > 0) begin
        hold_left = hold_req;
        hold_req = 0;
      end
      if (rst) begin
        out_ready <= 1'b0;
      end else if (hold_left > 0) begin
        out_ready <= 1'b0;
        hold_left--;
      end else begin
        out_ready <= ($urandom_range(99) >= snk_idle_pct);
      end
    end
  end

  initial begin
    while (cycle_count < CYCLE_LIMIT) begin
      @(posedge clk);
      cycle_count++;
    end
    $display("FAIL multi_queue_fifo_manager_core");
    $finish;
  end

  initial begin
    rst <= 1'b1;
    in_valid <= 1'b0;
    cmd <= '0;
    queue_sel <= '0;
    req_depth <= '0;
    data_in <= '0;

    add_row(CMD_GET, 0, 0, '0, 1, ST_INACTIVE, 0, '0, 0);
    add_row(CMD_PUT, 15, REQ_MAX, '1, 1, ST_INACTIVE, 0, '0, 0);
    add_row(CMD_COUNT, 7, 0, '0, 1, ST_INACTIVE, 0, '0, 0);
    add_row(CMD_FREE, 3, 0, '0, 1, ST_INACTIVE, 0, '0, 0);
    add_row(CMD_SPARE_LO, 5, MAX_DEPTH, '1, 1, ST_OK, 0, '0, 0);
    add_row(CMD_SPARE_HI, 15, REQ_MAX, '1, 1, ST_OK, 0, '0, 0);
    add_row(CMD_ALLOC, 15, 0, '0, 1, ST_OK, 0, '0, 0);
    add_row(CMD_ALLOC, 0, 1, '1, 1, ST_OK, 1, '0, 0);
    add_row(CMD_ALLOC, 0, REQ_MAX, '0, 1, ST_OK, 2, '0, 0);
    add_row(CMD_ALLOC, 0, MAX_DEPTH + 1, '0, 1, ST_OK, 3, '0, 0);
    add_row(CMD_PUT, 1, 0, '1, 1, ST_OK, 0, '0, 1);
    add_row(CMD_PUT, 1, 0, '0, 1, ST_FULL, 0, '0, 1);
    add_row(CMD_GET, 1, 0, '0, 1, ST_OK, 0, '1, 0);
    add_row(CMD_GET, 1, 0, '0, 1, ST_EMPTY, 0, '0, 0);
    add_row(CMD_PUT, 1, 0, 32'hA5A5_5A5A, 0, ST_OK, 0, '0, 0);
    add_row(CMD_GET, 1, 0, '0, 0, ST_OK, 0, '0, 0);
    add_row(CMD_PUT, 2, 0, 32'h8000_0001, 0, ST_OK, 0, '0, 0);
    add_row(CMD_PUT, 2, 0, 32'h7FFF_FFFE, 0, ST_OK, 0, '0, 0);
    add_row(CMD_COUNT, 2, 0, '0, 1, ST_OK, 0, '0, 2);
    add_row(CMD_GET, 2, 0, '0, 0, ST_OK, 0, '0, 0);
    add_row(CMD_FREE, 2, 0, '0, 1, ST_OK, 0, '0, 0);
    add_row(CMD_COUNT, 2, 0, '0, 1, ST_INACTIVE, 0, '0, 0);
    add_row(CMD_ALLOC, 9, 2, '0, 1, ST_OK, 2, '0, 0);
    add_row(CMD_GET, 2, 0, '0, 1, ST_EMPTY, 0, '0, 0);

    repeat (9) @(posedge clk);
    rst <= 1'b0;

    foreach (dir_rows[i])
      send_word(dir_rows[i].c, dir_rows[i].qs, dir_rows[i].rd, dir_rows[i].din,
                dir_rows[i].typed, dir_rows[i].want);

    run_phase(PHASE_WORDS, 27, 70);
    // hold the sender until every result is back
    in_valid <= 1'b0;
    do @(posedge clk); while (pending_results.size() != 0);
    run_phase(PHASE_WORDS, 70, 27);
    hold_req = RX_HOLD_CYCLES;
    run_phase(PHASE_WORDS, 0, 0);

    in_valid <= 1'b0;
    do @(posedge clk); while (pending_results.size() != 0);
    repeat (20) @(posedge clk);
    if (errors == 0) begin
      $display("PASS multi_queue_fifo_manager_core");
    end else begin
      $display("FAIL multi_queue_fifo_manager_core");
    end
    $finish;
  end

endmodule

FILE: multi_queue_fifo_manager_core.f
design/mqf_pkg.sv
design/mqf_ram.sv
design/mqf_qsel.sv
design/multi_queue_fifo_manager_core.sv
design/mqf_checker.sv
verif/tb_multi_queue_fifo_manager_core.sv
